>>> rtl/lsfg_pkg.sv
// shared types, constants and codes of the led strip frame generator
package lsfg_pkg;

	localparam int STRIP_SLOTS = 32;
	localparam int IDX_W       = $clog2(STRIP_SLOTS);
	localparam int CNT_W       = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	localparam logic [7:0]  LEVEL_MARK     = 8'hE0;
	localparam logic [4:0]  LEVEL_MAX      = 5'd31;
	localparam logic [7:0]  FULL_BRIGHT    = 8'hFF;
	localparam logic [31:0] RESET_PIXEL    = 32'hFF00_0000;
	localparam logic [3:0]  TAIL_BYTES_MAX = 4'd8;
	localparam logic [3:0]  BYTES_PER_WORD = 4'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTES  = 2'd2;

	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_FILL   = 2'd1,
		OP_SHOW   = 2'd2,
		OP_ROTATE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [IDX_W-1:0] pixel_index;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       level;
		logic [7:0]       rotate_steps;
	} req_t;

	typedef struct packed {
		logic [31:0] frame_word;
		logic [2:0]  byte_count;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic set_px;
		logic fill;
		logic start_frame;
		logic start_rot;
		logic mod_step;
		logic rot_step;
		logic form;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic mod_done;
		logic rot_done;
		logic word_last;
	} stat_t;

endpackage

>>> rtl/lsfg_ctrl.sv
// controller state machine of the led strip frame generator
module lsfg_ctrl import lsfg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] op,
	input  logic       rsp_ready,
	input  stat_t      stat,
	output logic       req_ready,
	output logic       rsp_valid,
	output cmd_t       cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MOD  = 5'b00010,
		S_ROT  = 5'b00100,
		S_PROD = 5'b01000,
		S_SEND = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (op)
						OP_SET: begin
							cmd.set_px = 1'b1;
						end
						OP_FILL: begin
							cmd.fill        = 1'b1;
							cmd.start_frame = 1'b1;
							state_d         = S_PROD;
						end
						OP_SHOW: begin
							cmd.start_frame = 1'b1;
							state_d         = S_PROD;
						end
						OP_ROTATE: begin
							cmd.start_rot = 1'b1;
							state_d       = S_MOD;
						end
					endcase
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (stat.mod_done) begin
					state_d = S_ROT;
				end
			end
			S_ROT: begin
				if (stat.rot_done) begin
					state_d = S_IDLE;
				end else begin
					cmd.rot_step = 1'b1;
				end
			end
			S_PROD: begin
				cmd.form = 1'b1;
				state_d  = S_SEND;
			end
			S_SEND: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					if (stat.word_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.advance = 1'b1;
						state_d     = S_PROD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/lsfg_dp.sv
// datapath: config registers, pixel store, rotate counters and frame word former
module lsfg_dp import lsfg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	input  cmd_t                  cmd,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output stat_t                 stat,
	output rsp_t                  rsp
);

	typedef enum logic [1:0] {
		W_START = 2'd0,
		W_PIXEL = 2'd1,
		W_END   = 2'd2
	} word_kind_t;

	logic [7:0]       brightness_q;
	logic [CNT_W-1:0] count_q;
	logic [3:0]       tail_bytes_q;
	logic [31:0]      store_q [STRIP_SLOTS];
	logic [7:0]       rem_q;
	logic [2:0]       k_q;
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       left_q;
	word_kind_t       kind_q;
	logic             scaled_q;
	rsp_t             rsp_q;

	logic [CNT_W-1:0] n_eff;
	logic [3:0]       eb_eff;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] set_idx;
	logic [4:0]       lvl;
	logic [31:0]      px_word;
	logic [31:0]      fill_word;
	logic [13:0]      div_sh;
	logic [31:0]      rd_word;
	logic [31:0]      shown_word;
	logic [2:0]       end_cnt;
	logic [31:0]      end_word;
	rsp_t             rsp_d;

	// floor(c * br / 255) for a 16-bit product
	function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] br);
		logic [15:0] p;
		logic [15:0] s;
		p = c * br;
		s = p + 16'd1 + {8'd0, p[15:8]};
		return s[15:8];
	endfunction

	always_comb begin
		if (count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (count_q > CNT_W'(STRIP_SLOTS)) begin
			n_eff = CNT_W'(STRIP_SLOTS);
		end else begin
			n_eff = count_q;
		end
	end

	assign eb_eff   = (tail_bytes_q > TAIL_BYTES_MAX) ? TAIL_BYTES_MAX : tail_bytes_q;
	assign last_idx = IDX_W'(n_eff - CNT_W'(1));
	assign set_idx  = (CNT_W'(req.pixel_index) >= n_eff) ? last_idx : req.pixel_index;
	assign lvl      = (req.level > {3'd0, LEVEL_MAX}) ? LEVEL_MAX : req.level[4:0];
	assign px_word  = {LEVEL_MARK | {3'd0, lvl}, req.blue, req.green, req.red};
	assign fill_word = {LEVEL_MARK | {3'd0, LEVEL_MAX}, req.blue, req.green, req.red};
	assign div_sh   = 14'(n_eff) << k_q;

	// register writes, expected only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= FULL_BRIGHT;
			count_q      <= CNT_W'(STRIP_SLOTS);
			tail_bytes_q <= BYTES_PER_WORD;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_BRIGHTNESS) begin
				brightness_q <= cfg_data;
			end else if (cfg_index == CFG_PIXEL_COUNT) begin
				count_q <= cfg_data[CNT_W-1:0];
			end else if (cfg_index == CFG_TAIL_BYTES) begin
				tail_bytes_q <= cfg_data[3:0];
			end
		end
	end

	// pixel store: each entry sees its own write, fill and its upper neighbor (entry 0 for the last pixel)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STRIP_SLOTS; i++) begin
				store_q[i] <= RESET_PIXEL;
			end
		end else begin
			for (int i = 0; i < STRIP_SLOTS; i++) begin
				if (cmd.set_px && (set_idx == IDX_W'(i))) begin
					store_q[i] <= px_word;
				end else if (cmd.fill && (CNT_W'(i) < n_eff)) begin
					store_q[i] <= fill_word;
				end else if (cmd.rot_step && (CNT_W'(i) < n_eff)) begin
					if (last_idx == IDX_W'(i)) begin
						store_q[i] <= store_q[0];
					end else begin
						store_q[i] <= store_q[(i + 1) % STRIP_SLOTS];
					end
				end
			end
		end
	end

	// steps mod n by restoring subtraction, then one-place rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			k_q   <= '0;
		end else if (cmd.start_rot) begin
			rem_q <= req.rotate_steps;
			k_q   <= 3'd7;
		end else if (cmd.mod_step) begin
			if (14'(rem_q) >= div_sh) begin
				rem_q <= rem_q - div_sh[7:0];
			end
			k_q <= k_q - 3'd1;
		end else if (cmd.rot_step) begin
			rem_q <= rem_q - 8'd1;
		end
	end

	// frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= W_START;
			idx_q    <= '0;
			left_q   <= '0;
			scaled_q <= 1'b0;
		end else if (cmd.start_frame) begin
			kind_q   <= W_START;
			idx_q    <= '0;
			scaled_q <= (req.op == OP_SHOW);
		end else if (cmd.advance) begin
			unique case (kind_q)
				W_START: begin
					kind_q <= W_PIXEL;
				end
				W_PIXEL: begin
					if (idx_q == last_idx) begin
						kind_q <= W_END;
						left_q <= eb_eff;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				W_END: begin
					left_q <= left_q - BYTES_PER_WORD;
				end
				default: begin
					kind_q <= W_START;
				end
			endcase
		end
	end

	assign rd_word = store_q[idx_q];
	assign end_cnt = (left_q > BYTES_PER_WORD) ? 3'd4 : left_q[2:0];

	always_comb begin
		if (scaled_q && (brightness_q != FULL_BRIGHT)) begin
			shown_word = {rd_word[31:24], scale8(rd_word[23:16], brightness_q),
				scale8(rd_word[15:8], brightness_q), scale8(rd_word[7:0], brightness_q)};
		end else begin
			shown_word = rd_word;
		end
	end

	always_comb begin
		unique case (end_cnt)
			3'd1:    end_word = 32'hFF00_0000;
			3'd2:    end_word = 32'hFFFF_0000;
			3'd3:    end_word = 32'hFFFF_FF00;
			default: end_word = 32'hFFFF_FFFF;
		endcase
	end

	always_comb begin
		rsp_d = '0;
		unique case (kind_q)
			W_START: begin
				rsp_d.frame_word = '0;
				rsp_d.byte_count = 3'd4;
				rsp_d.last       = 1'b0;
			end
			W_PIXEL: begin
				rsp_d.frame_word = shown_word;
				rsp_d.byte_count = 3'd4;
				rsp_d.last       = (idx_q == last_idx) && (eb_eff == '0);
			end
			W_END: begin
				rsp_d.frame_word = end_word;
				rsp_d.byte_count = end_cnt;
				rsp_d.last       = (left_q <= BYTES_PER_WORD);
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.form) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp            = rsp_q;
	assign stat.mod_done  = (k_q == '0);
	assign stat.rot_done  = (rem_q == '0);
	assign stat.word_last = rsp_q.last;

endmodule

>>> rtl/led_strip_frame_generator_unit.sv
// top level of the led strip frame generator: controller, datapath and checks
// set pixel writes one entry; rotate runs the restoring modulo, then one single-place
//   rotation per remaining step of (steps mod pixel_count)
// show and fill: each frame word is formed, then sent as a beat (form, then beat),
//   up to 35 words, 1 + pixels + ceil(tail bytes / 4) words per frame
// one request at a time; a new request is taken only once the previous one is done
// reset: every pixel level 31 and black, brightness 255, 32 pixels, 4 end bytes
module led_strip_frame_generator_unit import lsfg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	// frame word channel
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	// register write channel, always ready
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	// sequencer: decodes the op, walks modulo, rotation and frame words
	lsfg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.op        (req.op),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.cmd       (cmd)
	);

	// store, counters and the word former; the output beat is registered here
	lsfg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cfg_wr    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.rsp       (rsp)
	);

	// no new request while a frame beat is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while a frame beat is pending");

	// the last beat of a frame returns the block to idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ready && rsp.last) |=> req_ready)
		else $error("block not idle after the final frame beat");

	// only the closing end word may be partial
	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.byte_count == 3'd4))
		else $error("partial word before the end of the frame");

	// a beat always carries one to four bytes
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.byte_count != 3'd0 && rsp.byte_count <= 3'd4))
		else $error("byte count out of range");

endmodule
